[hdl/hpq_pkg.sv]
// hpq_pkg: shared constants, codes and transaction types of the min-heap priority queue
`default_nettype none
package hpq_pkg;

	localparam int CAPACITY = 64;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int CH_W     = IDX_W + 2;
	localparam int DATA_W   = 32;

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic                     opcode;
		logic signed [DATA_W-1:0] value;
	} hpq_in_t;

	typedef struct packed {
		logic [1:0]               status;
		logic signed [DATA_W-1:0] popped_value;
		logic signed [DATA_W-1:0] top_value;
		logic [6:0]               entry_count;
		logic                     is_empty;
	} hpq_out_t;

	typedef struct packed {
		logic                     en;
		logic [IDX_W-1:0]         addr;
		logic signed [DATA_W-1:0] data;
	} hpq_wr_t;

endpackage
`default_nettype wire

[hdl/min_heap_priority_queue_top.sv]
// min_heap_priority_queue_top: sift sequencer with one shared signed comparator
// a push climbs one level at a time and stops early when its parent is not larger; a pop sifts
// down one node at a time; rejects and a pop to empty go straight to done
// one transaction at a time; busy is high from the cycle after acceptance through done
// done is high for one cycle with the result; the receiver cannot stall it
// asynchronous reset empties the heap; entry storage is not cleared
`default_nettype none
module min_heap_priority_queue_top (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire hpq_pkg::hpq_in_t  cmd,
	output logic                   done,
	output hpq_pkg::hpq_out_t      result
);
	import hpq_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_PUSH_UP,
		S_PUSH_CMP,
		S_POP_RD,
		S_POP_LD,
		S_DOWN_L,
		S_DOWN_LC,
		S_DOWN_RC,
		S_DOWN_MV,
		S_DONE
	} state_t;

	state_t                   state_q;
	logic [CNT_W-1:0]         count_q;
	logic [IDX_W-1:0]         idx_q;
	logic [IDX_W-1:0]         best_idx_q;
	logic                     best_child_q;
	logic signed [DATA_W-1:0] cur_q;
	logic signed [DATA_W-1:0] best_val_q;
	logic signed [DATA_W-1:0] top_q;
	logic signed [DATA_W-1:0] popped_q;
	logic [1:0]               status_q;

	hpq_wr_t                  wr;
	logic [IDX_W-1:0]         raddr;
	logic signed [DATA_W-1:0] rdata;
	logic signed [DATA_W-1:0] cmp_a;
	logic signed [DATA_W-1:0] cmp_b;
	logic                     lt;
	logic [IDX_W-1:0]         parent;
	logic [CH_W-1:0]          left;
	logic [CH_W-1:0]          right;
	logic [CH_W-1:0]          n_ext;
	logic                     has_left;
	logic                     has_right;

	hpq_ram u_ram (
		.clk   (clk),
		.wr    (wr),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign parent    = (idx_q - IDX_W'(1)) >> 1;
	assign left      = {1'b0, idx_q, 1'b1};
	assign right     = left + CH_W'(1);
	assign n_ext     = CH_W'(count_q);
	assign has_left  = left < n_ext;
	assign has_right = right < n_ext;

	// shared comparator
	always_comb begin
		unique case (state_q)
			S_PUSH_CMP: begin
				cmp_a = cur_q;
				cmp_b = rdata;
			end
			S_DOWN_LC: begin
				cmp_a = rdata;
				cmp_b = cur_q;
			end
			default: begin
				cmp_a = rdata;
				cmp_b = best_val_q;
			end
		endcase
	end
	assign lt = cmp_a < cmp_b;

	// ram control
	always_comb begin
		wr    = '0;
		raddr = '0;
		unique case (state_q)
			S_PUSH_UP: begin
				if (idx_q == '0) begin
					wr.en   = 1'b1;
					wr.addr = idx_q;
					wr.data = cur_q;
				end else begin
					raddr = parent;
				end
			end
			S_PUSH_CMP: begin
				wr.en   = 1'b1;
				wr.addr = idx_q;
				wr.data = lt ? rdata : cur_q;
			end
			S_POP_RD: begin
				raddr = count_q[IDX_W-1:0];
			end
			S_DOWN_L: begin
				if (has_left) begin
					raddr = left[IDX_W-1:0];
				end else begin
					wr.en   = 1'b1;
					wr.addr = idx_q;
					wr.data = cur_q;
				end
			end
			S_DOWN_LC: begin
				raddr = right[IDX_W-1:0];
			end
			S_DOWN_MV: begin
				wr.en   = 1'b1;
				wr.addr = idx_q;
				wr.data = best_child_q ? best_val_q : cur_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			idx_q        <= '0;
			best_idx_q   <= '0;
			best_child_q <= 1'b0;
			cur_q        <= '0;
			best_val_q   <= '0;
			top_q        <= '0;
			popped_q     <= '0;
			status_q     <= ST_OK;
		end else begin
			if (wr.en && wr.addr == '0) begin
				top_q <= wr.data;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						if (cmd.opcode == OP_PUSH) begin
							popped_q <= '0;
							if (count_q == CNT_W'(CAPACITY)) begin
								status_q <= ST_FULL;
								state_q  <= S_DONE;
							end else begin
								status_q <= ST_OK;
								cur_q    <= cmd.value;
								idx_q    <= count_q[IDX_W-1:0];
								count_q  <= count_q + CNT_W'(1);
								state_q  <= S_PUSH_UP;
							end
						end else begin
							if (count_q == '0) begin
								popped_q <= '0;
								status_q <= ST_EMPTY;
								state_q  <= S_DONE;
							end else begin
								status_q <= ST_OK;
								popped_q <= top_q;
								count_q  <= count_q - CNT_W'(1);
								state_q  <= (count_q == CNT_W'(1)) ? S_DONE : S_POP_RD;
							end
						end
					end
				end
				S_PUSH_UP: begin
					state_q <= (idx_q == '0) ? S_DONE : S_PUSH_CMP;
				end
				S_PUSH_CMP: begin
					if (lt) begin
						idx_q   <= parent;
						state_q <= S_PUSH_UP;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_POP_RD: begin
					state_q <= S_POP_LD;
				end
				S_POP_LD: begin
					cur_q   <= rdata;
					idx_q   <= '0;
					state_q <= S_DOWN_L;
				end
				S_DOWN_L: begin
					state_q <= has_left ? S_DOWN_LC : S_DONE;
				end
				S_DOWN_LC: begin
					best_child_q <= lt;
					best_idx_q   <= left[IDX_W-1:0];
					best_val_q   <= lt ? rdata : cur_q;
					state_q      <= has_right ? S_DOWN_RC : S_DOWN_MV;
				end
				S_DOWN_RC: begin
					if (lt) begin
						best_child_q <= 1'b1;
						best_idx_q   <= right[IDX_W-1:0];
						best_val_q   <= rdata;
					end
					state_q <= S_DOWN_MV;
				end
				S_DOWN_MV: begin
					if (best_child_q) begin
						idx_q   <= best_idx_q;
						state_q <= S_DOWN_L;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = state_q != S_IDLE;
	assign done = state_q == S_DONE;

	always_comb begin
		result.status       = status_q;
		result.popped_value = popped_q;
		result.top_value    = (count_q != '0) ? top_q : '0;
		result.entry_count  = 7'(count_q);
		result.is_empty     = count_q == '0;
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held longer than one cycle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("transaction accepted without going busy");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> CNT_W'(wr.addr) < count_q)
		else $error("heap write outside live entries");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		done && status_q == ST_FULL |-> count_q == CNT_W'(CAPACITY))
		else $error("full status with heap not full");

endmodule
`default_nettype wire

[hdl/hpq_ram.sv]
// hpq_ram: heap entry storage, one write port and one registered read port
`default_nettype none
module hpq_ram (
	input  wire logic                             clk,
	input  wire hpq_pkg::hpq_wr_t                 wr,
	input  wire logic [hpq_pkg::IDX_W-1:0]        raddr,
	output logic signed [hpq_pkg::DATA_W-1:0]     rdata
);
	import hpq_pkg::*;

	logic signed [DATA_W-1:0] mem [CAPACITY];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

[tb/min_heap_priority_queue_checker.sv]
// min_heap_priority_queue_checker: shadow heap that predicts every result and compares it with the block
`default_nettype none
module min_heap_priority_queue_checker (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic              busy,
	input  wire hpq_pkg::hpq_in_t  cmd,
	input  wire logic              done,
	input  wire hpq_pkg::hpq_out_t result,
	output int                     mismatches,
	output int                     outstanding,
	output int                     push_count,
	output int                     pop_count,
	output int                     full_count,
	output int                     empty_count
);
	import hpq_pkg::*;

	logic signed [DATA_W-1:0] shadow_heap [CAPACITY];
	int unsigned              shadow_count;
	hpq_out_t                 pending_results [$];
	int                       error_total;
	int                       push_total;
	int                       pop_total;
	int                       full_total;
	int                       empty_total;

	function automatic hpq_out_t predict_heap_op(hpq_in_t op);
		hpq_out_t                 r;
		int unsigned              slot;
		int unsigned              parent;
		int unsigned              left;
		int unsigned              right;
		int unsigned              best;
		logic signed [DATA_W-1:0] tmp;
		bit                       moving;
		r = '0;
		r.status = ST_OK;
		if (op.opcode == OP_PUSH) begin
			if (shadow_count >= CAPACITY) begin
				r.status = ST_FULL;
			end else begin
				slot = shadow_count;
				shadow_heap[slot] = op.value;
				shadow_count++;
				moving = 1'b1;
				while (moving && slot > 0) begin
					parent = (slot - 1) / 2;
					if (shadow_heap[slot] < shadow_heap[parent]) begin
						tmp = shadow_heap[slot];
						shadow_heap[slot] = shadow_heap[parent];
						shadow_heap[parent] = tmp;
						slot = parent;
					end else begin
						moving = 1'b0;
					end
				end
			end
		end else begin
			if (shadow_count == 0) begin
				r.status = ST_EMPTY;
			end else begin
				r.popped_value = shadow_heap[0];
				shadow_count--;
				shadow_heap[0] = shadow_heap[shadow_count];
				slot = 0;
				moving = 1'b1;
				while (moving && slot < shadow_count) begin
					left = 2 * slot + 1;
					right = left + 1;
					best = slot;
					// left child wins a tie
					if (left < shadow_count && shadow_heap[left] < shadow_heap[best])
						best = left;
					if (right < shadow_count && shadow_heap[right] < shadow_heap[best])
						best = right;
					if (best == slot) begin
						moving = 1'b0;
					end else begin
						tmp = shadow_heap[slot];
						shadow_heap[slot] = shadow_heap[best];
						shadow_heap[best] = tmp;
						slot = best;
					end
				end
			end
		end
		r.top_value = (shadow_count > 0) ? shadow_heap[0] : '0;
		r.entry_count = 7'(shadow_count);
		r.is_empty = (shadow_count == 0);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		hpq_out_t expected;
		if (!arst_n) begin
			shadow_count = 0;
			pending_results.delete();
			error_total = 0;
			push_total = 0;
			pop_total = 0;
			full_total = 0;
			empty_total = 0;
		end else begin
			if (done) begin
				if (pending_results.size() == 0) begin
					$error("result with no transaction waiting");
					error_total++;
				end else begin
					expected = pending_results.pop_front();
					if (result.status !== expected.status) begin
						$error("status expected %0d got %0d", expected.status, result.status);
						error_total++;
					end
					if (result.popped_value !== expected.popped_value) begin
						$error("popped_value expected %0d got %0d",
							expected.popped_value, result.popped_value);
						error_total++;
					end
					if (result.top_value !== expected.top_value) begin
						$error("top_value expected %0d got %0d",
							expected.top_value, result.top_value);
						error_total++;
					end
					if (result.entry_count !== expected.entry_count) begin
						$error("entry_count expected %0d got %0d",
							expected.entry_count, result.entry_count);
						error_total++;
					end
					if (result.is_empty !== expected.is_empty) begin
						$error("is_empty expected %0d got %0d",
							expected.is_empty, result.is_empty);
						error_total++;
					end
				end
			end
			if (start && !busy) begin
				expected = predict_heap_op(cmd);
				pending_results = {pending_results, expected};
				case (expected.status)
					ST_OK: begin
						if (cmd.opcode == OP_PUSH)
							push_total++;
						else
							pop_total++;
					end
					ST_FULL: begin
						full_total++;
					end
					ST_EMPTY: begin
						empty_total++;
					end
					default: begin
					end
				endcase
			end
		end
		mismatches <= error_total;
		outstanding <= pending_results.size();
		push_count <= push_total;
		pop_count <= pop_total;
		full_count <= full_total;
		empty_count <= empty_total;
	end

endmodule
`default_nettype wire

[tb/min_heap_priority_queue_top_test.sv]
// min_heap_priority_queue_top_test: stimulus, watchdog and verdict for the min-heap priority queue
`default_nettype none
module min_heap_priority_queue_top_test;
	import hpq_pkg::*;

	localparam int RANDOM_ITEMS   = 1500;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TAIL_CYCLES    = 40;

	typedef enum {SPREAD_WIDE, SPREAD_NARROW, SPREAD_EDGE} spread_t;
	typedef enum {PHASE_FILL, PHASE_DRAIN, PHASE_MIXED} phase_t;

	logic     clk = 1'b0;
	logic     arst_n;
	logic     start;
	logic     busy;
	hpq_in_t  cmd;
	logic     done;
	hpq_out_t result;

	int mismatches;
	int outstanding;
	int push_count;
	int pop_count;
	int full_count;
	int empty_count;
	int idle_cycles = 0;
	int sent_total = 0;
	int drain_pauses = 0;
	bit gaps_off = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	min_heap_priority_queue_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.result (result)
	);

	min_heap_priority_queue_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.cmd         (cmd),
		.done        (done),
		.result      (result),
		.mismatches  (mismatches),
		.outstanding (outstanding),
		.push_count  (push_count),
		.pop_count   (pop_count),
		.full_count  (full_count),
		.empty_count (empty_count)
	);

	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("min_heap_priority_queue_top_test failed");
			$finish;
		end
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (gaps_off || r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 4);
		else if (r < 97)
			return $urandom_range(5, 35);
		else
			return $urandom_range(36, 80);
	endfunction

	function automatic logic signed [DATA_W-1:0] pick_value(spread_t spread);
		logic signed [DATA_W-1:0] v;
		v = $urandom;
		case (spread)
			SPREAD_NARROW: begin
				// dense range, many ties
				v = $urandom_range(0, 6);
				v = v - 3;
			end
			SPREAD_EDGE: begin
				case ($urandom_range(0, 7))
					0: v = 32'sh8000_0000;
					1: v = 32'sh8000_0001;
					2: v = -1;
					3: v = 0;
					4: v = 1;
					5: v = 32'sh7fff_fffe;
					6: v = 32'sh7fff_ffff;
					default: v = $urandom;
				endcase
			end
			default: begin
			end
		endcase
		return v;
	endfunction

	task automatic issue_cmd(input logic op, input logic signed [DATA_W-1:0] operand);
		hpq_in_t     next_cmd;
		int unsigned gap;
		next_cmd.opcode = op;
		next_cmd.value = operand;
		start <= 1'b1;
		cmd <= next_cmd;
		do @(posedge clk); while (busy);
		sent_total++;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		drain_pauses++;
	endtask

	initial begin
		phase_t      phase;
		spread_t     spread;
		int unsigned push_pct;
		int unsigned phase_len;
		int          directed_len;
		logic        op;
		start <= 1'b0;
		cmd <= '0;
		arst_n <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty pop, extremes, ties, then drain past empty
		issue_cmd(OP_POP, $urandom);
		issue_cmd(OP_PUSH, 7);
		issue_cmd(OP_PUSH, 32'sh7fff_ffff);
		issue_cmd(OP_PUSH, 32'sh8000_0000);
		issue_cmd(OP_PUSH, 0);
		issue_cmd(OP_PUSH, -1);
		issue_cmd(OP_PUSH, -1);
		issue_cmd(OP_PUSH, 7);
		issue_cmd(OP_PUSH, 1);
		issue_cmd(OP_PUSH, 32'sh8000_0000);
		repeat (10) issue_cmd(OP_POP, $urandom);
		wait_drained();
		directed_len = sent_total;

		while (sent_total < directed_len + RANDOM_ITEMS) begin
			phase = phase_t'($urandom_range(0, 2));
			spread = spread_t'($urandom_range(0, 2));
			gaps_off = ($urandom_range(0, 4) == 0);
			case (phase)
				PHASE_FILL:  push_pct = 85;
				PHASE_DRAIN: push_pct = 15;
				default:     push_pct = 50;
			endcase
			phase_len = $urandom_range(30, 150);
			repeat (phase_len) begin
				if (sent_total < directed_len + RANDOM_ITEMS) begin
					op = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
					if ($urandom_range(0, 9) < 7)
						issue_cmd(op, pick_value(spread));
					else
						issue_cmd(op, pick_value(spread_t'($urandom_range(0, 2))));
				end
			end
			if ($urandom_range(0, 3) == 0)
				wait_drained();
		end

		start <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("%0d commands sent (%0d directed), %0d pauses until all results were in",
			sent_total, directed_len, drain_pauses);
		$display("accepted %0d pushes and %0d pops, refused %0d pushes when full, %0d pops when empty",
			push_count, pop_count, full_count, empty_count);
		if (mismatches == 0 && outstanding == 0) begin
			$display("min_heap_priority_queue_top_test passed");
		end else begin
			$display("min_heap_priority_queue_top_test failed");
		end
		$finish;
	end

endmodule
`default_nettype wire
